@@ hw/rtl/olte_pkg.sv @@
// Package for the ordered list table engine: sizes, command and status codes,
// the control word broadcast to the cell row, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olte_pkg;

   localparam int DEPTH     = 64;
   localparam int KEY_W     = 8;
   localparam int PAY_W     = 32;
   localparam int POS_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND      = 3'd0,
      CMD_INSERT      = 3'd1,
      CMD_REMOVE_LAST = 3'd2,
      CMD_REMOVE_AT   = 3'd3,
      CMD_SEARCH      = 3'd4,
      CMD_CLEAR       = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_MATCH  = 2'd1,
      SEQ_SELECT = 2'd2
   } seq_state_type;

   // Control word shared by every cell of the row.
   typedef struct packed {
      cell_op_type        op;
      logic               search;
      logic [POS_W-1:0]   pos;
      logic [CNT_W-1:0]   count;
      logic [KEY_W-1:0]   key;
      logic [PAY_W-1:0]   payload;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/olte_req_if.sv @@
// Request channel of the ordered list table engine: valid/ready plus command.
// Depends on olte_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface olte_req_if
   import olte_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [POS_W-1:0]   position;
   logic [KEY_W-1:0]   entry_key;
   logic [PAY_W-1:0]   entry_payload;

   modport source (output valid, output cmd, output position, output entry_key,
                   output entry_payload, input ready);
   modport sink   (input valid, input cmd, input position, input entry_key,
                   input entry_payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/olte_rsp_if.sv @@
// Response channel of the ordered list table engine: valid/ready plus result.
// Depends on olte_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface olte_rsp_if
   import olte_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 found;
   logic [POS_W-1:0]     found_position;
   logic [KEY_W-1:0]     out_key;
   logic [PAY_W-1:0]     out_payload;
   logic [CNT_W-1:0]     live_count;

   modport source (output valid, output status, output found, output found_position,
                   output out_key, output out_payload, output live_count,
                   input ready);
   modport sink   (input valid, input status, input found, input found_position,
                   input out_key, input out_payload, input live_count,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/olte_cell.sv @@
// One slot of the list row: holds a key and payload, shifts with its neighbours
// and flags a key match or a position hit. Depends on olte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olte_cell
   import olte_pkg::*;
(
   input  wire                 clock,
   input  wire cell_ctrl_type  ctrl,
   input  wire  [POS_W-1:0]    cell_index,
   input  wire  [KEY_W-1:0]    lower_key,
   input  wire  [PAY_W-1:0]    lower_payload,
   input  wire  [KEY_W-1:0]    upper_key,
   input  wire  [PAY_W-1:0]    upper_payload,
   output logic [KEY_W-1:0]    key,
   output logic [PAY_W-1:0]    payload,
   output logic                hit
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0] payload_ff, payload_in;

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (cell_index == ctrl.pos) begin
               key_in     = ctrl.key;
               payload_in = ctrl.payload;
            end else if (cell_index > ctrl.pos) begin
               key_in     = lower_key;
               payload_in = lower_payload;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= ctrl.pos) begin
               key_in     = upper_key;
               payload_in = upper_payload;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   // Search: live slot whose key matches. Otherwise: the addressed slot.
   assign hit = ctrl.search ? ((key_ff == ctrl.key) && ({1'b0, cell_index} < ctrl.count))
                            : (cell_index == ctrl.pos);

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ordered_list_table_engine.sv @@
// Ordered list table engine: a row of DEPTH shifting cells holding a contiguous list.
// A request is registered on acceptance, its hits are captured in the hit register in MATCH,
// and in SELECT the lowest-hit select and mux feed the response register. One request in
// flight, so a new request is taken once the previous response has been taken.
// Reset (synchronous, active high) empties the list and clears the response valid; cell
// contents are not cleared. Depends on olte_pkg, olte_req_if, olte_rsp_if, olte_cell.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_table_engine
   import olte_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   olte_req_if.sink    req_ch,
   olte_rsp_if.source  rsp_ch
);

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   seq_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Request held for the duration of the command
   cell_op_type          op_ff;
   status_type           status_ff;
   logic                 search_ff;
   logic                 clear_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PAY_W-1:0]     payload_ff;

   // Decode of the incoming request against the current count
   cell_op_type          op_dec;
   status_type           status_dec;
   logic                 search_dec;
   logic                 clear_dec;
   logic [POS_W-1:0]     pos_dec;
   logic [CNT_W-1:0]     count_dec;

   // Sequencer outputs
   logic                 accept;
   logic                 capture_hits;
   logic                 commit;

   // Cell row
   cell_ctrl_type        ctrl;
   logic [KEY_W-1:0]     cell_key   [DEPTH];
   logic [PAY_W-1:0]     cell_pay   [DEPTH];
   logic [DEPTH-1:0]     hit_w;
   logic [DEPTH-1:0]     hit_ff;

   // Select of the lowest hit
   logic [DEPTH-1:0]     first_hit;
   logic [KEY_W-1:0]     sel_key;
   logic [PAY_W-1:0]     sel_pay;
   logic [POS_W-1:0]     sel_pos;
   logic                 any_hit;

   // Response register
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]     rsp_fpos_ff, rsp_fpos_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0]     rsp_pay_ff, rsp_pay_in;

   // ---------------------------------------------------------------------
   // Request decode: resolve the effective position and the error status
   // ---------------------------------------------------------------------
   assign count_dec = CNT_W'(count_ff - 1'b1);

   always_comb begin
      op_dec     = CELL_HOLD;
      status_dec = STAT_OK;
      search_dec = 1'b0;
      clear_dec  = 1'b0;
      pos_dec    = req_ch.position;
      case (req_ch.cmd)
         CMD_APPEND, CMD_INSERT: begin
            if (req_ch.cmd == CMD_APPEND) begin
               pos_dec = count_ff[POS_W-1:0];
            end
            if (count_ff >= CNT_W'(DEPTH)) begin
               status_dec = STAT_FULL;
            end else if ({1'b0, pos_dec} > count_ff) begin
               status_dec = STAT_RANGE;
            end else begin
               op_dec = CELL_INSERT;
            end
         end
         CMD_REMOVE_LAST, CMD_REMOVE_AT: begin
            if (req_ch.cmd == CMD_REMOVE_LAST) begin
               pos_dec = count_dec[POS_W-1:0];
            end
            if (count_ff == '0) begin
               status_dec = STAT_EMPTY;
            end else if ({1'b0, pos_dec} >= count_ff) begin
               status_dec = STAT_RANGE;
            end else begin
               op_dec = CELL_REMOVE;
            end
         end
         CMD_SEARCH: search_dec = 1'b1;
         CMD_CLEAR:  clear_dec  = 1'b1;
         default: ;  // unused codes: no operation
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: IDLE -> MATCH (register hits) -> SELECT (mux, shift, respond)
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:   if (accept) state_in = SEQ_MATCH;
         SEQ_MATCH:  state_in = SEQ_SELECT;
         SEQ_SELECT: state_in = SEQ_IDLE;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      capture_hits = 1'b0;
      commit       = 1'b0;
      req_ch.ready = 1'b0;
      case (state_ff)
         SEQ_IDLE:   req_ch.ready = !rsp_valid_ff;
         SEQ_MATCH:  capture_hits = 1'b1;
         SEQ_SELECT: commit       = 1'b1;
         default: ;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the decoded request until the command commits
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_dec;
         status_ff  <= status_dec;
         search_ff  <= search_dec;
         clear_ff   <= clear_dec;
         pos_ff     <= pos_dec;
         key_ff     <= req_ch.entry_key;
         payload_ff <= req_ch.entry_payload;
      end
   end

   // ---------------------------------------------------------------------
   // Cell row: every cell sees the same control word; shifts only on commit
   // ---------------------------------------------------------------------
   always_comb begin
      ctrl.op      = commit ? op_ff : CELL_HOLD;
      ctrl.search  = search_ff;
      ctrl.pos     = pos_ff;
      ctrl.count   = count_ff;
      ctrl.key     = key_ff;
      ctrl.payload = payload_ff;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_W-1:0] lo_key, up_key;
      logic [PAY_W-1:0] lo_pay, up_pay;

      if (g == 0) begin : g_bottom
         assign lo_key = '0;
         assign lo_pay = '0;
      end else begin : g_lower
         assign lo_key = cell_key[g-1];
         assign lo_pay = cell_pay[g-1];
      end

      // The top slot has no upper neighbour: it keeps its own, now dead, contents
      if (g == DEPTH - 1) begin : g_top
         assign up_key = cell_key[g];
         assign up_pay = cell_pay[g];
      end else begin : g_upper
         assign up_key = cell_key[g+1];
         assign up_pay = cell_pay[g+1];
      end

      olte_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .cell_index    (POS_W'(g)),
         .lower_key     (lo_key),
         .lower_payload (lo_pay),
         .upper_key     (up_key),
         .upper_payload (up_pay),
         .key           (cell_key[g]),
         .payload       (cell_pay[g]),
         .hit           (hit_w[g])
      );
   end

   // Register the hit vector before the table moves
   always_ff @(posedge clock) begin
      if (capture_hits) begin
         hit_ff <= hit_w;
      end
   end

   // ---------------------------------------------------------------------
   // Lowest hit: isolate the least significant set bit, then one-hot mux
   // ---------------------------------------------------------------------
   assign first_hit = hit_ff & (~hit_ff + DEPTH'(1));
   assign any_hit   = |hit_ff;

   always_comb begin
      sel_key = '0;
      sel_pay = '0;
      sel_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_key = sel_key | ({KEY_W{first_hit[i]}} & cell_key[i]);
         sel_pay = sel_pay | ({PAY_W{first_hit[i]}} & cell_pay[i]);
         sel_pos = sel_pos | ({POS_W{first_hit[i]}} & POS_W'(i));
      end
   end

   // ---------------------------------------------------------------------
   // Commit: update the count and load the response register
   // ---------------------------------------------------------------------
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_found_in  = 1'b0;
         rsp_fpos_in   = '0;
         rsp_key_in    = '0;
         rsp_pay_in    = '0;
         case (op_ff)
            CELL_INSERT: count_in = CNT_W'(count_ff + 1'b1);
            CELL_REMOVE: begin
               count_in   = count_dec;
               rsp_key_in = sel_key;
               rsp_pay_in = sel_pay;
            end
            default: ;
         endcase
         if (clear_ff) begin
            count_in = '0;
         end
         if (search_ff && any_hit) begin
            rsp_found_in = 1'b1;
            rsp_fpos_in  = sel_pos;
            rsp_key_in   = sel_key;
            rsp_pay_in   = sel_pay;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
   end

   // Live count is the count after the command, held with the response
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.found          = rsp_found_ff;
   assign rsp_ch.found_position = rsp_fpos_ff;
   assign rsp_ch.out_key        = rsp_key_ff;
   assign rsp_ch.out_payload    = rsp_pay_ff;
   assign rsp_ch.live_count     = count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count above depth");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == SEQ_MATCH))
      else $error("accepted request did not start a match pass");

   a_commit_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SELECT) |=> rsp_valid_ff)
      else $error("commit did not raise a response");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SELECT && status_ff != STAT_OK) |=> $stable(count_ff))
      else $error("count changed on a rejected request");

endmodule

`default_nettype wire
